### rtl/core/gsl_pkg.sv
// shared constants, codes and controller/datapath interface types
package gsl_pkg;

  localparam int DEPTH  = 4096;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = ADDR_W + 1;
  localparam int DATA_W = 32;
  localparam int PEEK_W = 16;
  localparam int CNT_W  = $clog2(PEEK_W + 1);

  localparam logic [POS_W-1:0] DEPTH_POS = DEPTH[POS_W-1:0];
  localparam logic [CNT_W-1:0] PEEK_N    = PEEK_W[CNT_W-1:0];

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SEARCH = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    RD_LAST,
    RD_PEEK,
    RD_GAL,
    RD_MID
  } rd_sel_t;

  typedef enum logic [1:0] {
    RES_END,
    RES_BELOW,
    RES_LO
  } res_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_LAST,
    S_PEEK,
    S_PEEK_LAST,
    S_PEEK_DEC,
    S_GAL,
    S_GAL_CMP,
    S_BIS,
    S_BIS_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     ld_req;
    rd_sel_t  rd_sel;
    logic     peek_init;
    logic     peek_issue;
    logic     gal_init;
    logic     gal_dbl;
    logic     bis_from_end;
    logic     bis_from_peek;
    logic     mid_ld;
    logic     bis_lo;
    logic     bis_hi;
    logic     res_ld;
    res_sel_t res_sel;
    logic     out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic lt;
    logic peek_last;
    logic below_full;
    logic gal_over;
    logic bis_open;
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/core/gsl_ram.sv
// generic single write port, single read port ram with registered read
module gsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/gsl_ctrl.sv
// search sequencer: last check, peek, gallop, bisection
module gsl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              search_req,
  input  gsl_pkg::dp_sts_t  sts,
  output gsl_pkg::dp_cmd_t  cmd,
  output logic              busy
);

  gsl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gsl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel  = gsl_pkg::RD_MID;
    cmd.res_sel = gsl_pkg::RES_END;
    case (state_r)
      gsl_pkg::S_IDLE: begin
        if (search_req) begin
          cmd.ld_req = 1'b1;
          state_nxt  = gsl_pkg::S_CHECK;
        end
      end
      gsl_pkg::S_CHECK: begin
        if (sts.empty) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = gsl_pkg::RES_END;
          state_nxt   = gsl_pkg::S_DONE;
        end else begin
          cmd.rd_sel = gsl_pkg::RD_LAST;
          state_nxt  = gsl_pkg::S_LAST;
        end
      end
      gsl_pkg::S_LAST: begin
        if (sts.lt) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = gsl_pkg::RES_END;
          state_nxt   = gsl_pkg::S_DONE;
        end else begin
          cmd.peek_init = 1'b1;
          state_nxt     = gsl_pkg::S_PEEK;
        end
      end
      gsl_pkg::S_PEEK: begin
        cmd.rd_sel     = gsl_pkg::RD_PEEK;
        cmd.peek_issue = 1'b1;
        if (sts.peek_last) begin
          state_nxt = gsl_pkg::S_PEEK_LAST;
        end
      end
      gsl_pkg::S_PEEK_LAST: begin
        state_nxt = gsl_pkg::S_PEEK_DEC;
      end
      gsl_pkg::S_PEEK_DEC: begin
        if (!sts.below_full) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = gsl_pkg::RES_BELOW;
          state_nxt   = gsl_pkg::S_DONE;
        end else begin
          cmd.gal_init = 1'b1;
          state_nxt    = gsl_pkg::S_GAL;
        end
      end
      gsl_pkg::S_GAL: begin
        if (sts.gal_over) begin
          cmd.bis_from_end = 1'b1;
          state_nxt        = gsl_pkg::S_BIS;
        end else begin
          cmd.rd_sel = gsl_pkg::RD_GAL;
          state_nxt  = gsl_pkg::S_GAL_CMP;
        end
      end
      gsl_pkg::S_GAL_CMP: begin
        if (sts.lt) begin
          cmd.gal_dbl = 1'b1;
          state_nxt   = gsl_pkg::S_GAL;
        end else begin
          cmd.bis_from_peek = 1'b1;
          state_nxt         = gsl_pkg::S_BIS;
        end
      end
      gsl_pkg::S_BIS: begin
        if (sts.bis_open) begin
          cmd.rd_sel = gsl_pkg::RD_MID;
          cmd.mid_ld = 1'b1;
          state_nxt  = gsl_pkg::S_BIS_CMP;
        end else begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = gsl_pkg::RES_LO;
          state_nxt   = gsl_pkg::S_DONE;
        end
      end
      gsl_pkg::S_BIS_CMP: begin
        if (sts.lt) begin
          cmd.bis_lo = 1'b1;
        end else begin
          cmd.bis_hi = 1'b1;
        end
        state_nxt = gsl_pkg::S_BIS;
      end
      gsl_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = gsl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gsl_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != gsl_pkg::S_IDLE);

endmodule

### rtl/core/gsl_dp.sv
// search datapath: element store, bounds, counters and result register
module gsl_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gsl_pkg::dp_cmd_t                  cmd,
  output gsl_pkg::dp_sts_t                  sts,
  input  logic                              wr_en,
  input  logic        [gsl_pkg::ADDR_W-1:0] wr_addr,
  input  logic signed [gsl_pkg::DATA_W-1:0] value,
  input  logic        [gsl_pkg::POS_W-1:0]  range_begin,
  input  logic        [gsl_pkg::POS_W-1:0]  range_end,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic        [gsl_pkg::POS_W-1:0]  out_position
);

  localparam int PW = gsl_pkg::POS_W;
  localparam int CW = gsl_pkg::CNT_W;
  localparam int AW = gsl_pkg::ADDR_W;
  localparam int DW = gsl_pkg::DATA_W;

  logic [PW-1:0]        beg_r, end_r, jump_r, lo_r, hi_r, mid_r, res_r;
  logic signed [DW-1:0] key_r;
  logic [CW-1:0]        iss_r, below_r;
  logic                 pk_vld_r;
  logic                 out_valid_r;
  logic [PW-1:0]        out_pos_r;

  logic [PW-1:0]        beg_sat, end_sat, len, mid_calc, rd_pos, res_calc;
  logic [CW-1:0]        peek_n;
  logic [PW:0]          peek;
  logic [AW-1:0]        raddr;
  logic [DW-1:0]        rdata;
  logic                 lt;

  assign beg_sat = (range_begin > gsl_pkg::DEPTH_POS) ? gsl_pkg::DEPTH_POS : range_begin;
  assign end_sat = (range_end > gsl_pkg::DEPTH_POS) ? gsl_pkg::DEPTH_POS : range_end;

  assign len      = end_r - beg_r;
  assign peek_n   = (len >= {{(PW-CW){1'b0}}, gsl_pkg::PEEK_N}) ? gsl_pkg::PEEK_N : len[CW-1:0];
  assign peek     = {1'b0, beg_r} + {1'b0, jump_r};
  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);
  assign lt       = ($signed(rdata) < key_r);

  always_comb begin
    case (cmd.rd_sel)
      gsl_pkg::RD_LAST: rd_pos = end_r - {{(PW-1){1'b0}}, 1'b1};
      gsl_pkg::RD_PEEK: rd_pos = beg_r + {{(PW-CW){1'b0}}, iss_r};
      gsl_pkg::RD_GAL:  rd_pos = peek[PW-1:0];
      gsl_pkg::RD_MID:  rd_pos = mid_calc;
      default:          rd_pos = mid_calc;
    endcase
  end

  assign raddr = rd_pos[AW-1:0];

  always_comb begin
    case (cmd.res_sel)
      gsl_pkg::RES_END:   res_calc = end_r;
      gsl_pkg::RES_BELOW: res_calc = beg_r + {{(PW-CW){1'b0}}, below_r};
      gsl_pkg::RES_LO:    res_calc = lo_r;
      default:            res_calc = end_r;
    endcase
  end

  gsl_ram #(
    .WIDTH (DW),
    .DEPTH (gsl_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      beg_r <= beg_sat;
      end_r <= end_sat;
      key_r <= value;
    end
    if (cmd.peek_init) begin
      iss_r   <= '0;
      below_r <= '0;
    end else begin
      if (cmd.peek_issue) begin
        iss_r <= iss_r + {{(CW-1){1'b0}}, 1'b1};
      end
      if (pk_vld_r && lt) begin
        below_r <= below_r + {{(CW-1){1'b0}}, 1'b1};
      end
    end
    if (cmd.gal_init) begin
      jump_r <= {{(PW-CW){1'b0}}, gsl_pkg::PEEK_N};
    end else if (cmd.gal_dbl) begin
      jump_r <= jump_r << 1;
    end
    if (cmd.bis_from_end || cmd.bis_from_peek) begin
      lo_r <= beg_r + (jump_r >> 1) + {{(PW-1){1'b0}}, 1'b1};
    end else if (cmd.bis_lo) begin
      lo_r <= mid_r + {{(PW-1){1'b0}}, 1'b1};
    end
    if (cmd.bis_from_end) begin
      hi_r <= end_r;
    end else if (cmd.bis_from_peek) begin
      hi_r <= peek[PW-1:0] + {{(PW-1){1'b0}}, 1'b1};
    end else if (cmd.bis_hi) begin
      hi_r <= mid_r;
    end
    if (cmd.mid_ld) begin
      mid_r <= mid_calc;
    end
    if (cmd.res_ld) begin
      res_r <= res_calc;
    end
    if (cmd.out_ld) begin
      out_pos_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pk_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pk_vld_r <= cmd.peek_issue;
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.empty      = (beg_r >= end_r);
  assign sts.lt         = lt;
  assign sts.peek_last  = (iss_r == (peek_n - {{(CW-1){1'b0}}, 1'b1}));
  assign sts.below_full = (below_r == peek_n);
  assign sts.gal_over   = (peek >= {1'b0, end_r});
  assign sts.bis_open   = (lo_r < hi_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid    = out_valid_r;
  assign out_position = out_pos_r;

endmodule

### rtl/core/galloping_search_lower_bound.sv
// Lower-bound search over a 4096-entry store of signed 32-bit elements.
// A write transfer stores one element and does not stall the input. A search
// transfer takes the range [range_begin, range_end), both saturated to 4096,
// and a key, and returns the first position holding an element >= key, or
// range_end. The store has a single read port with a registered read, so each
// step issues a read and then compares: the block checks the range and its
// last element, peeks at the first n = min(len, 16) elements and, if all are
// below the key, gallops in doubling jumps until an element is not below the
// key or the gallop runs past the range end, then bisects, and hands over the
// result. An empty range, or a range whose last element is below the key,
// answers range_end without peeking. One item is worked on at a time; a
// finished position waits in the output register until it is taken and the
// next input transfer follows in the cycle after it is loaded there. Input is
// stalled during reset. Unwritten entries read as garbage.
module galloping_search_lower_bound (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic        [gsl_pkg::ADDR_W-1:0] in_addr,
  input  logic signed [gsl_pkg::DATA_W-1:0] in_value,
  input  logic        [gsl_pkg::POS_W-1:0]  in_range_begin,
  input  logic        [gsl_pkg::POS_W-1:0]  in_range_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic        [gsl_pkg::POS_W-1:0]  out_position
);

  gsl_pkg::dp_cmd_t cmd;
  gsl_pkg::dp_sts_t sts;
  logic             busy;
  logic             search_req;
  logic             wr_en;

  assign in_stall   = busy || !rst_n;
  assign search_req = in_valid && (in_command == gsl_pkg::CMD_SEARCH);
  assign wr_en      = in_valid && !in_stall && (in_command == gsl_pkg::CMD_WRITE);

  gsl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .search_req (search_req),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  gsl_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .wr_en        (wr_en),
    .wr_addr      (in_addr),
    .value        (in_value),
    .range_begin  (in_range_begin),
    .range_end    (in_range_end),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_position (out_position)
  );

endmodule
